>>> rtl/tpr_pkg.sv
// Shared types and constants for the tilt position radial clamp block.
package tpr_pkg;

  localparam int TILT_W     = 16;
  localparam int DZ_W       = 15;
  localparam int DIV_W      = 16;
  localparam int ORG_W      = 10;
  localparam int RAD_W      = 10;
  localparam int HALF_W     = 9;
  localparam int CORNER_W   = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DZ_W-1:0]   DEAD_ZONE_RST    = 15'd200;
  localparam logic [DIV_W-1:0]  SPEED_DIV_RST    = 16'd400;
  localparam logic [ORG_W-1:0]  ORIGIN_X_RST     = 10'd206;
  localparam logic [ORG_W-1:0]  ORIGIN_Y_RST     = 10'd206;
  localparam logic [RAD_W-1:0]  LIMIT_RADIUS_RST = 10'd186;
  localparam logic [HALF_W-1:0] HALF_EXTENT_RST  = 9'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_ZONE     = 3'd0,
    CFG_SPEED_DIVISOR = 3'd1,
    CFG_ORIGIN_X      = 3'd2,
    CFG_ORIGIN_Y      = 3'd3,
    CFG_LIMIT_RADIUS  = 3'd4,
    CFG_HALF_EXTENT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [DZ_W-1:0]   dead_zone;
    logic [DIV_W-1:0]  speed_divisor;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [RAD_W-1:0]  limit_radius;
    logic [HALF_W-1:0] half_extent;
  } cfg_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic                was_clamped;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

>>> rtl/tpr_alu.sv
// Shared adder-subtractor with carry out, used for every iterative step.
module tpr_alu
#(
  parameter int W = 50
)
(
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W:0] full;

  // When subtracting, the carry out is set exactly when a >= b.
  assign full  = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
  assign sum   = full[W-1:0];
  assign carry = full[W];

endmodule

>>> rtl/tpr_core.sv
// Sequencer and datapath: velocity divides, squared distance, root and clamp.
module tpr_core
  import tpr_pkg::*;
#(
  parameter int FRAC_BITS = 8
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [TILT_W-1:0]        tilt_x,
  input  logic [TILT_W-1:0]        tilt_y,
  input  cfg_t                     cfg,
  input  logic                     out_free,
  output core_stat_t               stat,
  output res_t                     res
);

  localparam int VW    = TILT_W + FRAC_BITS;      // velocity quotient
  localparam int DW    = TILT_W + 1 + FRAC_BITS;  // working position, signed
  localparam int AW    = TILT_W + FRAC_BITS;      // offset magnitude
  localparam int RW    = AW + 1;                  // root of squared distance
  localparam int UW    = 2 * RW;                  // shared unit width
  localparam int RQW   = RAD_W + FRAC_BITS;       // radius in fixed point
  localparam int PDW   = AW + RQW;                // offset times radius
  localparam int CNT_W = $clog2(PDW + 1);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_VSET   = 15'b000000000000010,
    ST_VDIV   = 15'b000000000000100,
    ST_VAPPLY = 15'b000000000001000,
    ST_MSET   = 15'b000000000010000,
    ST_SQ     = 15'b000000000100000,
    ST_RSET   = 15'b000000001000000,
    ST_ROOT   = 15'b000000010000000,
    ST_RCHK   = 15'b000000100000000,
    ST_CMSET  = 15'b000001000000000,
    ST_CMUL   = 15'b000010000000000,
    ST_CDSET  = 15'b000100000000000,
    ST_CDIV   = 15'b001000000000000,
    ST_CAPPLY = 15'b010000000000000,
    ST_DONE   = 15'b100000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                axis_r, axis_nxt;
  logic                clamp_r, clamp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [UW-1:0]       acc_r, acc_nxt;
  logic [UW-1:0]       opa_r, opa_nxt;
  logic [UW-1:0]       opb_r, opb_nxt;
  logic [RW-1:0]       dist_r, dist_nxt;
  logic [TILT_W-1:0]   tilt_x_r, tilt_x_nxt;
  logic [TILT_W-1:0]   tilt_y_r, tilt_y_nxt;
  logic [DW-1:0]       pos_x_r, pos_x_nxt;
  logic [DW-1:0]       pos_y_r, pos_y_nxt;

  logic [UW-1:0]       alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_carry;
  logic                last;

  logic [TILT_W-1:0]   t_sel;
  logic [TILT_W:0]     t_ext, mag, dz_ext, excess;
  logic [DIV_W-1:0]    divisor;
  logic [DW-1:0]       vq;

  logic [DW:0]         cx_e, cy_e, pos_x_e, pos_y_e, dx_x, dx_y;
  logic [AW-1:0]       ax_x, ax_y, ax_sel;
  logic                neg_sel;
  logic [DW-1:0]       c_sel, cq;
  logic [RW-1:0]       root, rq;
  logic                clamp_now;

  logic [DW:0]         half_e, vx, vy, vxb, vyb;

  localparam logic [CNT_W-1:0] CNT_VEL  = CNT_W'(VW);
  localparam logic [CNT_W-1:0] CNT_SQ   = CNT_W'(AW);
  localparam logic [CNT_W-1:0] CNT_ROOT = CNT_W'(RW);
  localparam logic [CNT_W-1:0] CNT_CMUL = CNT_W'(RQW);
  localparam logic [CNT_W-1:0] CNT_CDIV = CNT_W'(PDW);

  tpr_alu #(.W(UW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign last = (cnt_r == CNT_W'(1));

  // Operand routing into the shared unit.
  always_comb begin
    alu_a   = acc_r;
    alu_b   = opa_r;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_VDIV, ST_CDIV: begin
        alu_a   = {acc_r[UW-2:0], opb_r[UW-1]};
        alu_sub = 1'b1;
      end
      ST_ROOT: begin
        alu_a   = {acc_r[UW-3:0], opb_r[UW-1:UW-2]};
        alu_b   = {opa_r[UW-3:0], 2'b01};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Velocity operands for the axis being worked on.
  always_comb begin
    t_sel   = axis_r ? tilt_y_r : tilt_x_r;
    t_ext   = {t_sel[TILT_W-1], t_sel};
    mag     = t_sel[TILT_W-1] ? -t_ext : t_ext;
    dz_ext  = (TILT_W+1)'(cfg.dead_zone);
    excess  = (mag > dz_ext) ? (mag - dz_ext) : '0;
    divisor = (cfg.speed_divisor == '0) ? DIV_W'(1) : cfg.speed_divisor;
    vq      = DW'(opb_r[VW-1:0]);
  end

  // Offsets from the circle center.
  always_comb begin
    cx_e    = (DW+1)'({cfg.origin_x, {FRAC_BITS{1'b0}}});
    cy_e    = (DW+1)'({cfg.origin_y, {FRAC_BITS{1'b0}}});
    pos_x_e = {pos_x_r[DW-1], pos_x_r};
    pos_y_e = {pos_y_r[DW-1], pos_y_r};
    dx_x    = pos_x_e - cx_e;
    dx_y    = pos_y_e - cy_e;
    ax_x    = dx_x[DW] ? AW'(-dx_x) : AW'(dx_x);
    ax_y    = dx_y[DW] ? AW'(-dx_y) : AW'(dx_y);
    ax_sel  = axis_r ? ax_y : ax_x;
    neg_sel = axis_r ? dx_y[DW] : dx_x[DW];
    c_sel   = axis_r ? DW'(cy_e) : DW'(cx_e);
    cq      = DW'(opb_r[RQW-1:0]);
    root    = opa_r[RW-1:0];
    rq      = RW'({cfg.limit_radius, {FRAC_BITS{1'b0}}});
    // Outside the circle when the root is larger, or equal with a remainder left.
    clamp_now = (root > rq) || ((root == rq) && (acc_r != '0));
  end

  // Drawing corner, truncated toward zero to whole pixels.
  always_comb begin
    half_e = (DW+1)'({cfg.half_extent, {FRAC_BITS{1'b0}}});
    vx     = pos_x_e - half_e;
    vy     = pos_y_e - half_e;
    vxb    = vx + (vx[DW] ? (DW+1)'({FRAC_BITS{1'b1}}) : '0);
    vyb    = vy + (vy[DW] ? (DW+1)'({FRAC_BITS{1'b1}}) : '0);
    res.corner_x    = vxb[FRAC_BITS+CORNER_W-1:FRAC_BITS];
    res.corner_y    = vyb[FRAC_BITS+CORNER_W-1:FRAC_BITS];
    res.was_clamped = clamp_r;
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    clamp_nxt  = clamp_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    dist_nxt   = dist_r;
    tilt_x_nxt = tilt_x_r;
    tilt_y_nxt = tilt_y_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tilt_x_nxt = tilt_x;
          tilt_y_nxt = tilt_y;
          axis_nxt   = 1'b0;
          state_nxt  = ST_VSET;
        end
      end
      ST_VSET: begin
        // Dividend is the excess followed by the fraction zeros, left aligned.
        acc_nxt   = '0;
        opa_nxt   = UW'(divisor);
        opb_nxt   = {excess[TILT_W-1:0], {(UW-TILT_W){1'b0}}};
        cnt_nxt   = CNT_VEL;
        state_nxt = ST_VDIV;
      end
      ST_VDIV, ST_CDIV: begin
        acc_nxt = alu_carry ? alu_sum : alu_a;
        opb_nxt = {opb_r[UW-2:0], alu_carry};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last) begin
          state_nxt = (state_r == ST_VDIV) ? ST_VAPPLY : ST_CAPPLY;
        end
      end
      ST_VAPPLY: begin
        // X moves against the tilt, y with it.
        if (axis_r) begin
          pos_y_nxt = t_sel[TILT_W-1] ? (pos_y_r - vq) : (pos_y_r + vq);
          axis_nxt  = 1'b0;
          state_nxt = ST_MSET;
        end else begin
          pos_x_nxt = t_sel[TILT_W-1] ? (pos_x_r + vq) : (pos_x_r - vq);
          axis_nxt  = 1'b1;
          state_nxt = ST_VSET;
        end
      end
      ST_MSET: begin
        // The y square accumulates onto the x square.
        if (!axis_r) begin
          acc_nxt = '0;
        end
        opa_nxt   = UW'(ax_sel);
        opb_nxt   = UW'(ax_sel);
        cnt_nxt   = CNT_SQ;
        state_nxt = ST_SQ;
      end
      ST_SQ, ST_CMUL: begin
        if (opb_r[0]) begin
          acc_nxt = alu_sum;
        end
        opa_nxt = {opa_r[UW-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[UW-1:1]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last) begin
          if (state_r == ST_CMUL) begin
            state_nxt = ST_CDSET;
          end else if (axis_r) begin
            state_nxt = ST_RSET;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = ST_MSET;
          end
        end
      end
      ST_RSET: begin
        opb_nxt   = acc_r;
        acc_nxt   = '0;
        opa_nxt   = '0;
        cnt_nxt   = CNT_ROOT;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        acc_nxt = alu_carry ? alu_sum : alu_a;
        opa_nxt = {opa_r[UW-2:0], alu_carry};
        opb_nxt = {opb_r[UW-3:0], 2'b00};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last) begin
          state_nxt = ST_RCHK;
        end
      end
      ST_RCHK: begin
        clamp_nxt = clamp_now;
        dist_nxt  = root;
        axis_nxt  = 1'b0;
        state_nxt = clamp_now ? ST_CMSET : ST_DONE;
      end
      ST_CMSET: begin
        acc_nxt   = '0;
        opa_nxt   = UW'(ax_sel);
        opb_nxt   = UW'(rq);
        cnt_nxt   = CNT_CMUL;
        state_nxt = ST_CMUL;
      end
      ST_CDSET: begin
        opb_nxt   = acc_r << (UW - PDW);
        acc_nxt   = '0;
        opa_nxt   = UW'(dist_r);
        cnt_nxt   = CNT_CDIV;
        state_nxt = ST_CDIV;
      end
      ST_CAPPLY: begin
        if (axis_r) begin
          pos_y_nxt = neg_sel ? (c_sel - cq) : (c_sel + cq);
          state_nxt = ST_DONE;
        end else begin
          pos_x_nxt = neg_sel ? (c_sel - cq) : (c_sel + cq);
          axis_nxt  = 1'b1;
          state_nxt = ST_CMSET;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
      clamp_r <= 1'b0;
      cnt_r   <= '0;
      pos_x_r <= DW'({ORIGIN_X_RST, {FRAC_BITS{1'b0}}});
      pos_y_r <= DW'({ORIGIN_Y_RST, {FRAC_BITS{1'b0}}});
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      clamp_r <= clamp_nxt;
      cnt_r   <= cnt_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    dist_r   <= dist_nxt;
    tilt_x_r <= tilt_x_nxt;
    tilt_y_r <= tilt_y_nxt;
  end

endmodule

>>> rtl/tilt_position_radial_clamp_top.sv
// Top level: request handshakes, configuration registers and result register.
//
// Each tilt request moves a marker held in fixed point with FRAC_BITS fraction
// bits and returns its drawing corner and a clamp flag. The position is pulled
// back onto the circle by the clamp multiply-divides when it must be. A single
// shared adder-subtractor retires one quotient bit, one root bit or one
// multiplier bit per cycle for the two velocity divides, the squared distance,
// the square root and the two clamp multiply-divides. in_ready is high only
// between requests; a finished result waits in an output register while the
// next request is taken.
module tilt_position_radial_clamp_top
  import tpr_pkg::*;
#(
  parameter int FRAC_BITS = 8
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TILT_W-1:0]    in_tilt_x,
  input  logic [TILT_W-1:0]    in_tilt_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CORNER_W-1:0]  out_corner_x,
  output logic [CORNER_W-1:0]  out_corner_y,
  output logic                 out_was_clamped,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  core_stat_t stat;
  res_t       res;
  res_t       out_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready = stat.idle;
  assign out_free = !out_valid_r || out_ready;

  tpr_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && in_ready),
    .tilt_x   (in_tilt_x),
    .tilt_y   (in_tilt_y),
    .cfg      (cfg_r),
    .out_free (out_free),
    .stat     (stat),
    .res      (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEAD_ZONE:     cfg_nxt.dead_zone     = cfg_wdata[DZ_W-1:0];
        CFG_SPEED_DIVISOR: cfg_nxt.speed_divisor = cfg_wdata[DIV_W-1:0];
        CFG_ORIGIN_X:      cfg_nxt.origin_x      = cfg_wdata[ORG_W-1:0];
        CFG_ORIGIN_Y:      cfg_nxt.origin_y      = cfg_wdata[ORG_W-1:0];
        CFG_LIMIT_RADIUS:  cfg_nxt.limit_radius  = cfg_wdata[RAD_W-1:0];
        CFG_HALF_EXTENT:   cfg_nxt.half_extent   = cfg_wdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone     <= DEAD_ZONE_RST;
      cfg_r.speed_divisor <= SPEED_DIV_RST;
      cfg_r.origin_x      <= ORIGIN_X_RST;
      cfg_r.origin_y      <= ORIGIN_Y_RST;
      cfg_r.limit_radius  <= LIMIT_RADIUS_RST;
      cfg_r.half_extent   <= HALF_EXTENT_RST;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_corner_x    = out_r.corner_x;
  assign out_corner_y    = out_r.corner_y;
  assign out_was_clamped = out_r.was_clamped;

endmodule

>>> rtl/tpr_checker.sv
// Port-level checks for the tilt position radial clamp block, bound to the top.
module tpr_checker
  import tpr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CORNER_W-1:0]   out_corner_x,
  input logic [CORNER_W-1:0]   out_corner_y,
  input logic                  out_was_clamped
);

  // Reset leaves the block empty and ready for a request.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // One request at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in work");

  // A new result only follows a cycle in which the block was busy.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_corner_x) &&
      $stable(out_corner_y) && $stable(out_was_clamped)))
    else $error("pending result changed before it was taken");

endmodule

bind tilt_position_radial_clamp_top tpr_checker u_tpr_checker (.*);
